/* sv/event_cache_nearest_time_match_macros.svh */
// Assertion macros used by the checker file of the event cache.
// Depends on nothing; included by the checker only.
`ifndef EVENT_CACHE_NEAREST_TIME_MATCH_MACROS_SVH
`define EVENT_CACHE_NEAREST_TIME_MATCH_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ECM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define ECM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/ecnm_pkg.sv */
// Shared types and constants of the event cache.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ecnm_pkg;
    localparam int DEPTH_DEFAULT = 512;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_EPOCH  = 2'd2;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_KEPT     = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    localparam logic [1:0] REG_WINDOW   = 2'd0;
    localparam logic [1:0] REG_WILDCARD = 2'd1;
    localparam logic [1:0] REG_VERSION  = 2'd2;

    localparam logic [31:0] WINDOW_RESET  = 32'd5000;
    localparam logic [15:0] VERSION_RESET = 16'd1;

    typedef struct packed {
        logic [1:0]         action;
        logic [63:0]        seq_number;
        logic [31:0]        event_tick;
        logic [31:0]        received_tick;
        logic signed [31:0] key_a;
        logic signed [31:0] key_b;
        logic [15:0]        detail_word;
        logic [15:0]        payload_version;
        logic [31:0]        query_tick;
        logic               source_ready;
        logic [31:0]        epoch_value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [63:0]        hit_sequence;
        logic [31:0]        hit_event_tick;
        logic [31:0]        hit_received_tick;
        logic signed [31:0] hit_key_a;
        logic signed [31:0] hit_key_b;
        logic [15:0]        hit_detail;
        logic [63:0]        max_sequence;
    } result_t;

    // One stored cache entry.
    typedef struct packed {
        logic [63:0] seq;
        logic [31:0] evt;
        logic [31:0] rcv;
        logic [31:0] ka;
        logic [31:0] kb;
        logic [15:0] det;
    } entry_t;

    // Command handed from front to back.
    typedef struct packed {
        logic        is_find;
        logic        do_write;
        logic        do_clear;
        logic [2:0]  status;
        entry_t      entry;
        logic [31:0] qtick;
    } cmd_t;
endpackage
`default_nettype wire

/* sv/ecnm_front.sv */
// Front part: accepts requests, applies version and epoch rules.
// Depends on ecnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecnm_front
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  ecnm_pkg::req_t    req,
    input  wire  [15:0]       expected_version,
    input  wire               q_full,
    output logic              busy,
    output logic              q_push,
    output ecnm_pkg::cmd_t    q_data
);
    logic [31:0] epoch_reg;
    logic [31:0] epoch_next;
    logic        accept;
    logic        clr;

    assign busy   = q_full;
    assign accept = start && !busy;
    assign q_push = accept;

    // Classify the request and decide the epoch update.
    always_comb
    begin
        epoch_next = epoch_reg;
        clr = 1'b0;
        q_data = '0;
        q_data.entry.seq = req.seq_number;
        q_data.entry.evt = req.event_tick;
        q_data.entry.rcv = req.received_tick;
        q_data.entry.ka  = req.key_a;
        q_data.entry.kb  = req.key_b;
        q_data.entry.det = req.detail_word;
        q_data.qtick     = req.query_tick;
        q_data.status    = ecnm_pkg::ST_NONE;
        case (req.action)
            ecnm_pkg::ACT_INSERT:
            begin
                if (req.payload_version == expected_version)
                begin
                    q_data.do_write = 1'b1;
                    q_data.status = ecnm_pkg::ST_STORED;
                end
                else
                begin
                    q_data.status = ecnm_pkg::ST_REJECTED;
                end
            end
            ecnm_pkg::ACT_FIND:
            begin
                q_data.is_find = 1'b1;
            end
            ecnm_pkg::ACT_EPOCH:
            begin
                if (!req.source_ready)
                begin
                    if (epoch_reg != 32'd0)
                    begin
                        clr = 1'b1;
                        epoch_next = 32'd0;
                    end
                end
                else
                begin
                    if (epoch_reg != 32'd0 && req.epoch_value != 32'd0 &&
                        req.epoch_value != epoch_reg)
                    begin
                        clr = 1'b1;
                    end
                    if (req.epoch_value != 32'd0)
                    begin
                        epoch_next = req.epoch_value;
                    end
                end
                q_data.do_clear = clr;
                q_data.status = clr ? ecnm_pkg::ST_CLEARED : ecnm_pkg::ST_KEPT;
            end
            default:
            begin
                q_data.status = ecnm_pkg::ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= '0;
        end
        else if (accept)
        begin
            epoch_reg <= epoch_next;
        end
    end
endmodule
`default_nettype wire

/* sv/ecnm_queue.sv */
// Two-entry command queue between front and back.
// Depends on ecnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecnm_queue
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  ecnm_pkg::cmd_t  push_data,
    input  wire             pop,
    output logic            full,
    output logic            not_empty,
    output ecnm_pkg::cmd_t  head
);
    ecnm_pkg::cmd_t slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_reg];

    // Payload slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* sv/ecnm_back.sv */
// Back part: entry memory, FIFO pointers, scan for the nearest match.
// Depends on ecnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ecnm_back
#(
    parameter int CACHE_DEPTH = ecnm_pkg::DEPTH_DEFAULT
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                has_cmd,
    input  ecnm_pkg::cmd_t     cmd,
    input  wire  [31:0]        match_window,
    input  wire                zero_is_wildcard,
    output logic               pop,
    output logic               done,
    output ecnm_pkg::result_t  result
);
    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(CACHE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_HIT  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    ecnm_pkg::entry_t mem [CACHE_DEPTH];
    ecnm_pkg::entry_t rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] oldest_reg;
    logic [CW-1:0] fill_reg;
    logic [63:0]   maxseq_reg;
    logic [CW-1:0] idx_reg;
    logic          rd_valid_reg;
    logic [AW-1:0] best_reg;
    logic [31:0]   bdiff_reg;
    logic          found_reg;
    logic [2:0]    status_reg;
    logic          hit_reg;
    ecnm_pkg::cmd_t cur_reg;

    logic [AW-1:0] wr_pos;
    logic [AW-1:0] rd_pos;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          ka_ok, kb_ok, cand;
    logic [31:0]   mt, diff;
    logic [AW-1:0] cand_pos_reg;
    logic          start_cmd;

    // Circular address of the oldest entry plus the scan index.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [AW+1:0] s;
        s = {2'b0, a} + (AW+2)'(b);
        if (s >= (AW+2)'(CACHE_DEPTH))
        begin
            s = s - (AW+2)'(CACHE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign wr_pos   = (fill_reg >= DEPTH_C) ? oldest_reg : wrap_add(oldest_reg, fill_reg);
    assign rd_pos   = wrap_add(oldest_reg, idx_reg);
    assign start_cmd = (state_reg == S_IDLE) && has_cmd;
    assign pop = start_cmd;

    // Candidate test on the entry read in the previous cycle.
    always_comb
    begin
        ka_ok = (zero_is_wildcard && (cur_reg.entry.ka == 32'd0 || cur_reg.entry.ka[31])) ||
                (cur_reg.entry.ka == rd_data_reg.ka);
        kb_ok = (zero_is_wildcard && (cur_reg.entry.kb == 32'd0 || cur_reg.entry.kb[31])) ||
                (cur_reg.entry.kb == rd_data_reg.kb);
        mt = (rd_data_reg.rcv != 32'd0) ? rd_data_reg.rcv : rd_data_reg.evt;
        diff = (mt > cur_reg.qtick) ? mt - cur_reg.qtick : cur_reg.qtick - mt;
        cand = rd_valid_reg && ka_ok && kb_ok && (diff <= match_window) &&
               (!found_reg || diff < bdiff_reg);
    end

    // Read port address and enable.
    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = rd_pos;
        if (state_reg == S_SCAN)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == S_LAST && found_reg && !cand)
        begin
            rd_en = 1'b1;
            rd_addr = best_reg;
        end
        else if (state_reg == S_LAST && cand)
        begin
            rd_en = 1'b1;
            rd_addr = cand_pos_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_cmd)
                begin
                    if (cmd.is_find && fill_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg == fill_reg - CW'(1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = (found_reg || cand) ? S_HIT : S_OUT;
            end
            S_HIT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (start_cmd && cmd.do_write)
        begin
            mem[wr_pos] <= cmd.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Command payload and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (start_cmd)
        begin
            cur_reg <= cmd;
            status_reg <= cmd.status;
        end
        if (state_reg == S_SCAN)
        begin
            cand_pos_reg <= rd_pos;
        end
        if (cand)
        begin
            best_reg <= cand_pos_reg;
            bdiff_reg <= diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            oldest_reg   <= '0;
            fill_reg     <= '0;
            maxseq_reg   <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= (state_reg == S_SCAN);
            if (cand)
            begin
                found_reg <= 1'b1;
            end
            if (start_cmd)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                hit_reg <= 1'b0;
                if (cmd.do_write)
                begin
                    if (fill_reg >= DEPTH_C)
                    begin
                        oldest_reg <= wrap_add(oldest_reg, CW'(1));
                    end
                    else
                    begin
                        fill_reg <= fill_reg + CW'(1);
                    end
                    if (cmd.entry.seq > maxseq_reg)
                    begin
                        maxseq_reg <= cmd.entry.seq;
                    end
                end
                if (cmd.do_clear)
                begin
                    oldest_reg <= '0;
                    fill_reg <= '0;
                    maxseq_reg <= '0;
                end
            end
            if (state_reg == S_SCAN)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (state_reg == S_HIT)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    assign done = (state_reg == S_OUT);

    // Result assembly.
    always_comb
    begin
        result = '0;
        result.max_sequence = maxseq_reg;
        result.status = hit_reg ? ecnm_pkg::ST_FOUND : status_reg;
        if (hit_reg)
        begin
            result.hit_sequence      = rd_data_reg.seq;
            result.hit_event_tick    = rd_data_reg.evt;
            result.hit_received_tick = rd_data_reg.rcv;
            result.hit_key_a         = rd_data_reg.ka;
            result.hit_key_b         = rd_data_reg.kb;
            result.hit_detail        = rd_data_reg.det;
        end
    end
endmodule
`default_nettype wire

/* sv/event_cache_nearest_time_match.sv */
// Top level of the event cache with nearest-in-time lookup.
// Depends on ecnm_pkg, ecnm_front, ecnm_queue, ecnm_back.
//
//   channel   | handshake           | payload
//   request   | start / busy        | req (req_t)
//   result    | done (one cycle)    | result (result_t)
//   config    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// With the back part idle, an insert, epoch, unused code or find on an empty
// cache gives its result after acceptance through the queue slot and the result state.
// A find over n entries passes the queue slot, then the scan, last and result states,
// and a hit state on a match: the scan reads one entry per cycle, up to CACHE_DEPTH.
// The two-entry queue takes requests while a find scans; busy is high when full.
// Reset is asynchronous; no memory clearing pass is needed.
// Results cannot be stalled: done marks each for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module event_cache_nearest_time_match
#(
    parameter int CACHE_DEPTH = ecnm_pkg::DEPTH_DEFAULT
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  ecnm_pkg::req_t     req,
    output logic               done,
    output ecnm_pkg::result_t  result,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [1:0]         cfg_index,
    input  wire  [31:0]        cfg_data
);
    logic [31:0] window_reg;
    logic        wild_reg;
    logic [15:0] version_reg;
    logic           q_push, q_full, q_ne, q_pop;
    ecnm_pkg::cmd_t q_in, q_head;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= ecnm_pkg::WINDOW_RESET;
            wild_reg    <= 1'b0;
            version_reg <= ecnm_pkg::VERSION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ecnm_pkg::REG_WINDOW:   window_reg  <= cfg_data;
                ecnm_pkg::REG_WILDCARD: wild_reg    <= cfg_data[0];
                ecnm_pkg::REG_VERSION:  version_reg <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    ecnm_front u_front
    (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .expected_version(version_reg), .q_full(q_full), .busy(busy),
        .q_push(q_push), .q_data(q_in)
    );

    ecnm_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .pop(q_pop),
        .full(q_full), .not_empty(q_ne), .head(q_head)
    );

    ecnm_back #(.CACHE_DEPTH(CACHE_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n), .has_cmd(q_ne), .cmd(q_head),
        .match_window(window_reg), .zero_is_wildcard(wild_reg), .pop(q_pop),
        .done(done), .result(result)
    );
endmodule
`default_nettype wire

/* sv/ecnm_checker.sv */
// Port-level checker of the event cache, bound to the top level.
// Depends on ecnm_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "event_cache_nearest_time_match_macros.svh"
module ecnm_checker
(
    input wire               clk,
    input wire               rst_n,
    input wire               done,
    input ecnm_pkg::result_t result
);
    logic is_found;
    logic is_cleared;
    logic hit_zero;
    logic status_ok;

    // Decoded views of the result.
    assign is_found   = (result.status == ecnm_pkg::ST_FOUND);
    assign is_cleared = (result.status == ecnm_pkg::ST_CLEARED);
    assign hit_zero   = (result.hit_sequence == 64'd0) && (result.hit_detail == 16'd0);
    assign status_ok  = (result.status <= ecnm_pkg::ST_CLEARED);

    // Results never come in back to back.
    `ECM_ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done, "done two cycles in a row")
    // Status is always a defined code.
    `ECM_ASSERT_IMPL(a_status, clk, rst_n, done, status_ok, "bad status")
    // Hit fields are zero unless found.
    `ECM_ASSERT_IMPL(a_zero_hit, clk, rst_n, done && !is_found, hit_zero, "hit field set")
    // A clear result reports zero max sequence.
    `ECM_ASSERT_IMPL(a_clear_max, clk, rst_n, done && is_cleared, result.max_sequence == 64'd0, "clear kept sequence")
endmodule
bind event_cache_nearest_time_match ecnm_checker u_checker
(
    .clk(clk), .rst_n(rst_n), .done(done), .result(result)
);
`default_nettype wire
